// File: rtl/core/triangle_unit_normal_defines.svh
// assertion macros for the triangle unit normal block
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define TUN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define TUN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tun_pkg.sv
package tun_pkg;

    localparam int NUM_AXES = 3;

    typedef struct packed {
        logic valid;
        logic degenerate;
    } tun_ctl_t;

endpackage

// File: rtl/core/triangle_unit_normal.sv
// triangle_unit_normal: unit normal of the plane through points a, b, c
// input channel s_axis: one transfer carries nine signed coordinates
// output channel m_axis: normal_x/y/z in signed q1.FRAC, degenerate in tuser
// fully pipelined: one transfer accepted per cycle while s_axis_tready is high, no dependence between items
// the pipeline runs cross product, squares and sum, square root stages,
// divider stages and output register, in that order
// when m_axis_tready is low while m_axis_tvalid is high the whole pipeline holds and s_axis_tready drops;
// s_axis_tready equals m_axis_tready or an empty output slot
// reset clears all valid bits; data registers are not reset
// a zero cross product gives a zero normal with degenerate set
module triangle_unit_normal #(
    parameter int COORD_WIDTH = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // normal_x, normal_y, normal_z
    output logic [((3*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic                         m_axis_tuser
);
    import tun_pkg::*;
    `include "triangle_unit_normal_defines.svh"

    localparam int CW = COORD_WIDTH;
    localparam int FB = NORMAL_FRAC_BITS;
    localparam int OW = FB + 2;
    localparam int NW = 2 * CW + 3;
    localparam int ODW = ((3 * OW + 7) / 8) * 8;

    logic en;
    logic cv;
    logic signed [NW-1:0] nx, ny, nz;
    tun_ctl_t sctl, dctl;
    logic [NW-1:0] mx, my, mz, ng, rt;
    logic signed [OW-1:0] qx, qy, qz;

    assign en = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    tun_cross #(.CW(CW)) u_cross (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_axis_tvalid),
        .a_x(s_axis_tdata[0*CW +: CW]), .a_y(s_axis_tdata[1*CW +: CW]),
        .a_z(s_axis_tdata[2*CW +: CW]), .b_x(s_axis_tdata[3*CW +: CW]),
        .b_y(s_axis_tdata[4*CW +: CW]), .b_z(s_axis_tdata[5*CW +: CW]),
        .c_x(s_axis_tdata[6*CW +: CW]), .c_y(s_axis_tdata[7*CW +: CW]),
        .c_z(s_axis_tdata[8*CW +: CW]),
        .out_valid(cv), .n_x(nx), .n_y(ny), .n_z(nz)
    );

    tun_sqrt #(.CW(CW)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(cv),
        .n_x(nx), .n_y(ny), .n_z(nz),
        .out_ctl(sctl), .mag_x(mx), .mag_y(my), .mag_z(mz), .neg(ng), .root(rt)
    );

    tun_div #(.CW(CW), .FB(FB)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_ctl(sctl),
        .mag_x(mx), .mag_y(my), .mag_z(mz), .neg(ng), .root(rt),
        .out_ctl(dctl), .q_x(qx), .q_y(qy), .q_z(qz)
    );

    assign m_axis_tvalid = dctl.valid;
    assign m_axis_tuser = dctl.degenerate;
    assign m_axis_tdata = ODW'({qz, qy, qx});

    `TUN_ASSERT_IMP(a_degen_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata == '0, "degenerate result with nonzero normal")
    `TUN_ASSERT_NEXT(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `TUN_ASSERT_IMP(a_ready_rule, clk, rst_n, !m_axis_tvalid,
        s_axis_tready, "input blocked with empty output")
endmodule

// File: rtl/core/tun_cross.sv
module tun_cross #(
    parameter int CW = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [CW-1:0]   a_x,
    input  logic signed [CW-1:0]   a_y,
    input  logic signed [CW-1:0]   a_z,
    input  logic signed [CW-1:0]   b_x,
    input  logic signed [CW-1:0]   b_y,
    input  logic signed [CW-1:0]   b_z,
    input  logic signed [CW-1:0]   c_x,
    input  logic signed [CW-1:0]   c_y,
    input  logic signed [CW-1:0]   c_z,
    output logic                   out_valid,
    output logic signed [2*CW+2:0] n_x,
    output logic signed [2*CW+2:0] n_y,
    output logic signed [2*CW+2:0] n_z
);
    import tun_pkg::*;

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] ab_x_reg, ab_y_reg, ab_z_reg, ac_x_reg, ac_y_reg, ac_z_reg;
    logic signed [PW-1:0] p_reg [6];
    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [PW:0]   nx_reg, ny_reg, nz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ab_x_reg <= DW'(b_x) - DW'(a_x);
            ab_y_reg <= DW'(b_y) - DW'(a_y);
            ab_z_reg <= DW'(b_z) - DW'(a_z);
            ac_x_reg <= DW'(c_x) - DW'(a_x);
            ac_y_reg <= DW'(c_y) - DW'(a_y);
            ac_z_reg <= DW'(c_z) - DW'(a_z);
            p_reg[0] <= ab_y_reg * ac_z_reg;
            p_reg[1] <= ab_z_reg * ac_y_reg;
            p_reg[2] <= ab_z_reg * ac_x_reg;
            p_reg[3] <= ab_x_reg * ac_z_reg;
            p_reg[4] <= ab_x_reg * ac_y_reg;
            p_reg[5] <= ab_y_reg * ac_x_reg;
            nx_reg <= (PW+1)'(p_reg[0]) - (PW+1)'(p_reg[1]);
            ny_reg <= (PW+1)'(p_reg[2]) - (PW+1)'(p_reg[3]);
            nz_reg <= (PW+1)'(p_reg[4]) - (PW+1)'(p_reg[5]);
        end
    end

    assign out_valid = v3_reg;
    assign n_x = nx_reg;
    assign n_y = ny_reg;
    assign n_z = nz_reg;
endmodule

// File: rtl/core/tun_sqrt.sv
module tun_sqrt #(
    parameter int CW = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [2*CW+2:0] n_x,
    input  logic signed [2*CW+2:0] n_y,
    input  logic signed [2*CW+2:0] n_z,
    output tun_pkg::tun_ctl_t      out_ctl,
    output logic [2*CW+2:0]        mag_x,
    output logic [2*CW+2:0]        mag_y,
    output logic [2*CW+2:0]        mag_z,
    output logic [2*CW+2:0]        neg,
    output logic [2*CW+2:0]        root
);
    import tun_pkg::*;

    localparam int NW = 2 * CW + 3;
    localparam int MW = NW - 1;
    localparam int SW = 2 * MW + 2;
    localparam int RW = MW + 1;

    logic [MW-1:0] ma_reg, mb_reg, mc_reg;
    logic [2:0]    ng_reg;
    logic          v0_reg, v1_reg;
    logic [SW-1:0] sa_reg, sb_reg, sc_reg;
    logic [2:0]    ng1_reg;
    logic [MW-1:0] m1_reg [3];
    logic [SW-1:0] sum_reg;
    logic          v2_reg;
    logic [2:0]    ng2_reg;
    logic [MW-1:0] m2_reg [3];

    logic [SW-1:0] rem_reg [RW+1];
    logic [RW-1:0] rt_reg  [RW+1];
    logic          vs_reg  [RW+1];
    logic          dg_reg  [RW+1];
    logic [2:0]    ngs_reg [RW+1];
    logic [MW-1:0] ms_reg  [RW+1][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int i = 0; i <= RW; i++)
            begin
                vs_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            vs_reg[0] <= v2_reg;
            for (int i = 1; i <= RW; i++)
            begin
                vs_reg[i] <= vs_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ng_reg <= {n_z[NW-1], n_y[NW-1], n_x[NW-1]};
            ma_reg <= n_x[NW-1] ? MW'(-n_x) : MW'(n_x);
            mb_reg <= n_y[NW-1] ? MW'(-n_y) : MW'(n_y);
            mc_reg <= n_z[NW-1] ? MW'(-n_z) : MW'(n_z);
            sa_reg <= SW'(ma_reg * ma_reg);
            sb_reg <= SW'(mb_reg * mb_reg);
            sc_reg <= SW'(mc_reg * mc_reg);
            ng1_reg <= ng_reg;
            m1_reg[0] <= ma_reg;
            m1_reg[1] <= mb_reg;
            m1_reg[2] <= mc_reg;
            sum_reg <= sa_reg + sb_reg + sc_reg;
            ng2_reg <= ng1_reg;
            m2_reg <= m1_reg;
            rem_reg[0] <= sum_reg;
            rt_reg[0] <= '0;
            dg_reg[0] <= (sum_reg == '0);
            ngs_reg[0] <= ng2_reg;
            ms_reg[0] <= m2_reg;
            for (int i = 1; i <= RW; i++)
            begin
                logic [SW+1:0] trial;
                logic [SW+1:0] rr;
                trial = ((SW+2)'(rt_reg[i-1]) << (RW - i + 1))
                        + ((SW+2)'(1) << (2 * (RW - i)));
                rr = (SW+2)'(rem_reg[i-1]);
                if (rr >= trial)
                begin
                    rem_reg[i] <= SW'(rr - trial);
                    rt_reg[i] <= rt_reg[i-1] | (RW'(1) << (RW - i));
                end
                else
                begin
                    rem_reg[i] <= rem_reg[i-1];
                    rt_reg[i] <= rt_reg[i-1];
                end
                dg_reg[i] <= dg_reg[i-1];
                ngs_reg[i] <= ngs_reg[i-1];
                ms_reg[i] <= ms_reg[i-1];
            end
        end
    end

    assign out_ctl.valid = vs_reg[RW];
    assign out_ctl.degenerate = dg_reg[RW];
    assign mag_x = {1'b0, ms_reg[RW][0]};
    assign mag_y = {1'b0, ms_reg[RW][1]};
    assign mag_z = {1'b0, ms_reg[RW][2]};
    assign neg = NW'(ngs_reg[RW]);
    assign root = NW'(rt_reg[RW]);
endmodule

// File: rtl/core/tun_div.sv
module tun_div #(
    parameter int CW = 16,
    parameter int FB = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  tun_pkg::tun_ctl_t    in_ctl,
    input  logic [2*CW+2:0]      mag_x,
    input  logic [2*CW+2:0]      mag_y,
    input  logic [2*CW+2:0]      mag_z,
    input  logic [2*CW+2:0]      neg,
    input  logic [2*CW+2:0]      root,
    output tun_pkg::tun_ctl_t    out_ctl,
    output logic signed [FB+1:0] q_x,
    output logic signed [FB+1:0] q_y,
    output logic signed [FB+1:0] q_z
);
    import tun_pkg::*;

    localparam int NW = 2 * CW + 3;
    localparam int DS = FB + 1;

    logic [NW:0]   rem_reg [DS+1][NUM_AXES];
    logic [FB:0]   q_reg   [DS+1][NUM_AXES];
    logic [NW-1:0] rt_reg  [DS+1];
    logic [2:0]    ng_reg  [DS+1];
    tun_ctl_t      c_reg   [DS+1];
    logic signed [FB+1:0] o_reg [NUM_AXES];
    tun_ctl_t      co_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DS; i++)
            begin
                c_reg[i] <= '0;
            end
            co_reg <= '0;
        end
        else if (en)
        begin
            c_reg[0] <= in_ctl;
            for (int i = 1; i <= DS; i++)
            begin
                c_reg[i] <= c_reg[i-1];
            end
            co_reg <= c_reg[DS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0][0] <= {1'b0, mag_x};
            rem_reg[0][1] <= {1'b0, mag_y};
            rem_reg[0][2] <= {1'b0, mag_z};
            for (int a = 0; a < NUM_AXES; a++)
            begin
                q_reg[0][a] <= '0;
            end
            rt_reg[0] <= root;
            ng_reg[0] <= neg[2:0];
            for (int i = 1; i <= DS; i++)
            begin
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    logic [NW:0] r;
                    r = (i == 1) ? rem_reg[i-1][a] : (rem_reg[i-1][a] << 1);
                    if (r >= {1'b0, rt_reg[i-1]})
                    begin
                        rem_reg[i][a] <= r - {1'b0, rt_reg[i-1]};
                        q_reg[i][a] <= {q_reg[i-1][a][FB-1:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[i][a] <= r;
                        q_reg[i][a] <= {q_reg[i-1][a][FB-1:0], 1'b0};
                    end
                end
                rt_reg[i] <= rt_reg[i-1];
                ng_reg[i] <= ng_reg[i-1];
            end
            for (int a = 0; a < NUM_AXES; a++)
            begin
                if (c_reg[DS].degenerate)
                begin
                    o_reg[a] <= '0;
                end
                else if (ng_reg[DS][a])
                begin
                    o_reg[a] <= -$signed({1'b0, q_reg[DS][a]});
                end
                else
                begin
                    o_reg[a] <= $signed({1'b0, q_reg[DS][a]});
                end
            end
        end
    end

    assign out_ctl = co_reg;
    assign q_x = o_reg[0];
    assign q_y = o_reg[1];
    assign q_z = o_reg[2];
endmodule

// File: tb/sv/triangle_unit_normal_checker.sv
`timescale 1ns / 1ps

module triangle_unit_normal_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [47:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    output int           errors,
    output int           pending
);

    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        degen;
    } normal_t;

    normal_t expected_normals[$];

    function automatic longint unsigned isqrt(logic [127:0] v);
        logic [255:0] root;
        logic [255:0] trial;
        root = 0;
        for (int k = 67; k >= 0; k--) begin
            trial = root | (256'd1 << k);
            if (trial * trial <= 256'(v))
                root = trial;
        end
        return root[63:0];
    endfunction

    function automatic normal_t unit_normal(logic [143:0] d);
        logic signed [63:0] p [9];
        logic signed [63:0] ab [3];
        logic signed [63:0] ac [3];
        logic signed [127:0] n [3];
        logic [127:0] mag [3];
        logic [127:0] sum;
        logic [127:0] len;
        logic [127:0] q;
        logic [15:0] comp [3];
        normal_t r;
        for (int i = 0; i < 9; i++)
            p[i] = $signed(d[16*i +: 16]);
        for (int i = 0; i < 3; i++)
        begin
            ab[i] = p[3+i] - p[i];
            ac[i] = p[6+i] - p[i];
        end
        n[0] = ab[1] * ac[2] - ab[2] * ac[1];
        n[1] = ab[2] * ac[0] - ab[0] * ac[2];
        n[2] = ab[0] * ac[1] - ab[1] * ac[0];
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = n[i] < 0 ? -n[i] : n[i];
            sum += mag[i] * mag[i];
        end
        if (sum == 0)
        begin
            r.nx = 0;
            r.ny = 0;
            r.nz = 0;
            r.degen = 1'b1;
            return r;
        end
        len = isqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = (mag[i] << 14) / len;
            comp[i] = n[i] < 0 ? -q[15:0] : q[15:0];
        end
        r.nx = comp[0];
        r.ny = comp[1];
        r.nz = comp[2];
        r.degen = 1'b0;
        return r;
    endfunction

    assign pending = expected_normals.size();

    always @(posedge clk or negedge rst_n)
    begin
        normal_t e;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            errors <= 0;
            expected_normals.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_normals.push_back(unit_normal(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_normals.size() == 0)
                begin
                    $error("unexpected transfer on output: %h", m_axis_tdata);
                    errs++;
                end
                else
                begin
                    e = expected_normals.pop_front();
                    if (m_axis_tdata[15:0] !== e.nx)
                    begin
                        $error("normal_x expected %h got %h", e.nx, m_axis_tdata[15:0]);
                        errs++;
                    end
                    if (m_axis_tdata[31:16] !== e.ny)
                    begin
                        $error("normal_y expected %h got %h", e.ny, m_axis_tdata[31:16]);
                        errs++;
                    end
                    if (m_axis_tdata[47:32] !== e.nz)
                    begin
                        $error("normal_z expected %h got %h", e.nz, m_axis_tdata[47:32]);
                        errs++;
                    end
                    if (m_axis_tuser !== e.degen)
                    begin
                        $error("degenerate expected %b got %b", e.degen, m_axis_tuser);
                        errs++;
                    end
                end
            end
            errors <= errors + errs;
        end
    end

endmodule

// File: tb/sv/triangle_unit_normal_tb.sv
`timescale 1ns / 1ps

module triangle_unit_normal_tb;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tuser;
    int           errors;
    int           pending;
    int           idle_cycles = 0;
    bit           steady = 1'b0;
    logic [143:0] triangles[$];

    always #5 clk = ~clk;

    triangle_unit_normal dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    triangle_unit_normal_checker checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .errors(errors),
        .pending(pending)
    );

    function automatic logic [143:0] pack(logic [15:0] a[9]);
        logic [143:0] d;
        for (int i = 0; i < 9; i++)
            d[16*i +: 16] = a[i];
        return d;
    endfunction

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 15) - 8;
            2: return $urandom_range(0, 1) ? 16'h7fff - $urandom_range(0, 3)
                                            : 16'h8000 + $urandom_range(0, 3);
            default: return $urandom_range(0, 511) - 256;
        endcase
    endfunction

    task automatic add_directed();
        logic [15:0] c[9];
        // all coincident, extremes
        c = '{default: 16'h8000};
        triangles.push_back(pack(c));
        c = '{default: 16'h7fff};
        triangles.push_back(pack(c));
        c = '{default: 16'h0};
        triangles.push_back(pack(c));
        // axis-aligned normals
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        triangles.push_back(pack(c));
        c = '{0, 0, 0, 0, 1, 0, 0, 0, 1};
        triangles.push_back(pack(c));
        c = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
        triangles.push_back(pack(c));
        c = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
        triangles.push_back(pack(c));
        // collinear
        c = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
        triangles.push_back(pack(c));
        c = '{16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff};
        triangles.push_back(pack(c));
        // largest spans, then two other triangles
        c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
              16'h8000, 16'h7fff, 16'h8000};
        triangles.push_back(pack(c));
        c = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
              16'h7fff, 16'h7fff, 16'h8000};
        triangles.push_back(pack(c));
        c = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
              16'h7fff, 16'h7fff, 16'h8000};
        triangles.push_back(pack(c));
        c = '{16'hffff, 16'hffff, 16'hffff, 16'h5555, 16'haaaa, 16'h1234,
              16'hedcb, 16'h0f0f, 16'hf0f0};
        triangles.push_back(pack(c));
        c = '{0, 0, 0, 3, 4, 0, 4, 3, 0};
        triangles.push_back(pack(c));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || !steady)
            m_axis_tready <= rst_n && ($urandom_range(0, 99) >= 34);
        else
            m_axis_tready <= 1'b1;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] c[9];
        int mode;
        int sent;
        add_directed();
        for (int i = 0; i < 1350; i++)
        begin
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 9; k++)
                c[k] = rand_coord(mode);
            if ($urandom_range(0, 19) == 0)
                for (int k = 0; k < 3; k++)
                    c[6+k] = c[3+k];
            triangles.push_back(pack(c));
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        sent = 0;
        while (triangles.size() > 0)
        begin
            @(posedge clk);
            if (s_axis_tvalid && s_axis_tready)
            begin
                sent++;
                void'(triangles.pop_front());
            end
            steady = (sent > 500 && sent < 700);
            // a waiting transfer is held until accepted
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (triangles.size() > 0 && (steady || $urandom_range(0, 99) >= 34))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= triangles[0];
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
        steady = 1'b0;
        while (pending > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
